/* hw/rtl/fmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types, constants and the E4M3 compare used by the 2x2 max pooling
// block.
// ----------------------------------------------------------------------------
package fmp_pkg;

    localparam int CODE_W       = 8;
    localparam int SIZE_W       = 7;
    localparam int POS_W        = 6;
    localparam int MAX_WIDTH    = 64;
    localparam int HEIGHT_LIMIT = 64;
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int SLOT_W       = $clog2(LINE_DEPTH);
    localparam int INDEX_W      = 2;

    localparam logic [SIZE_W-1:0] SIZE_MIN      = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] WIDTH_MAX     = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX    = SIZE_W'(HEIGHT_LIMIT);
    localparam logic [SIZE_W-1:0] SIZE_RESET    = SIZE_W'(26);
    localparam logic [CODE_W-1:0] MAG_MASK      = 8'h7F;
    localparam logic [CODE_W-1:0] KEY_ZERO      = 8'h80;

    localparam logic [INDEX_W-1:0] REG_MAP_WIDTH  = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] REG_MAP_HEIGHT = INDEX_W'(1);

    // Action decoded for one accepted code.
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [SLOT_W-1:0]     slot;
        logic [CODE_W-1:0]     wr_data;
        logic [CODE_W-1:0]     holder;
        logic [CODE_W-1:0]     code;
        logic                  last;
    } scan_op_t;

    // Monotone key: zeros map to the middle, negatives below, positives above.
    function automatic logic [CODE_W-1:0] order_key(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] mag;
        mag = c & MAG_MASK;
        if (mag == '0)
            return KEY_ZERO;
        return c[CODE_W-1] ? (KEY_ZERO - mag) : (KEY_ZERO + mag);
    endfunction

    // Keeps held unless next is strictly larger.
    function automatic logic [CODE_W-1:0] keep_larger(input logic [CODE_W-1:0] held,
                                                      input logic [CODE_W-1:0] next);
        return (order_key(next) > order_key(held)) ? next : held;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        if (v < SIZE_MIN)
            return SIZE_MIN;
        if (v > hi)
            return hi;
        return v;
    endfunction

endpackage

/* hw/rtl/fp8_max_pool_2x2_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp8_max_pool_2x2_top
// 2x2 stride-2 max pooling over a raster stream of E4M3 codes.
// ----------------------------------------------------------------------------
// Usage: feed one code per transaction on in_valid/in_ready (field code), row
// by row, one map after another. On even rows the larger code of each
// horizontal pair goes into a 32-entry line store; on odd rows the second
// code of each pair reads that entry back and one pooled code leaves on
// out_valid/out_ready, with map_done set on the last result of the map.
// A trailing odd row or column is consumed without a result.
// Throughput is one code per cycle while in_ready is high. The result of a
// block passes through the line store read register, then the compare into
// the output register.
// Set map_width and map_height (indexes 0 and 1) through cfg_wr_en while the
// block is idle; any such write restarts the map at its top-left corner.
// Reset sets both sizes to 26 and the scan position to the top-left corner;
// the line store is not cleared, since every entry is written before use.
// When the receiver stalls, one result waits in the output register and one
// in the compare stage; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module fp8_max_pool_2x2_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fmp_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [fmp_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fmp_pkg::CODE_W-1:0]    code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fmp_pkg::CODE_W-1:0]    pooled_code,
    output logic                          map_done
);

    fmp_pkg::scan_op_t          op;
    logic                       accept;
    logic                       free;
    logic [fmp_pkg::CODE_W-1:0] upper;

    assign in_ready = free;
    assign accept   = in_valid && free;

    fmp_scan_ctrl u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .code      (code),
        .op        (op)
    );

    fmp_line_store u_store (
        .clk     (clk),
        .wr_en   (op.wr_en),
        .wr_addr (op.slot),
        .wr_data (op.wr_data),
        .rd_en   (op.rd_en),
        .rd_addr (op.slot),
        .rd_data (upper)
    );

    fmp_reduce u_reduce (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .upper       (upper),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pooled_code (pooled_code),
        .map_done    (map_done)
    );

endmodule

/* hw/rtl/fmp_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_line_store
// Line store of upper-row pair maxima: one write port, one registered read.
// ----------------------------------------------------------------------------
module fmp_line_store (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [fmp_pkg::SLOT_W-1:0]    wr_addr,
    input  logic [fmp_pkg::CODE_W-1:0]    wr_data,
    input  logic                          rd_en,
    input  logic [fmp_pkg::SLOT_W-1:0]    rd_addr,
    output logic [fmp_pkg::CODE_W-1:0]    rd_data
);

    logic [fmp_pkg::CODE_W-1:0] mem [fmp_pkg::LINE_DEPTH];
    logic [fmp_pkg::CODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/fmp_scan_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_scan_ctrl
// Size registers, raster position counters and the per-code decode.
// ----------------------------------------------------------------------------
module fmp_scan_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fmp_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [fmp_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                           accept,
    input  logic [fmp_pkg::CODE_W-1:0]     code,
    output fmp_pkg::scan_op_t              op
);

    logic [fmp_pkg::SIZE_W-1:0] width_reg, width_next;
    logic [fmp_pkg::SIZE_W-1:0] height_reg, height_next;
    logic [fmp_pkg::POS_W-1:0]  col_reg, col_next;
    logic [fmp_pkg::POS_W-1:0]  row_reg, row_next;
    logic [fmp_pkg::CODE_W-1:0] holder_reg, holder_next;

    logic [fmp_pkg::SIZE_W-1:0] w, h, used_w, used_h;
    logic [fmp_pkg::SIZE_W-1:0] col_ext, row_ext;
    logic                       in_block;

    always_comb
    begin
        w       = fmp_pkg::clamp_size(width_reg, fmp_pkg::WIDTH_MAX);
        h       = fmp_pkg::clamp_size(height_reg, fmp_pkg::HEIGHT_MAX);
        used_w  = {w[fmp_pkg::SIZE_W-1:1], 1'b0};
        used_h  = {h[fmp_pkg::SIZE_W-1:1], 1'b0};
        col_ext = {1'b0, col_reg};
        row_ext = {1'b0, row_reg};
        in_block = (col_ext < used_w) && (row_ext < used_h);

        op.slot    = col_reg[fmp_pkg::SLOT_W:1];
        op.wr_data = fmp_pkg::keep_larger(holder_reg, code);
        op.holder  = holder_reg;
        op.code    = code;
        op.wr_en   = accept && in_block && col_reg[0] && !row_reg[0];
        op.rd_en   = accept && in_block && col_reg[0] && row_reg[0];
        op.last    = (col_ext == used_w - 1'b1) && (row_ext == used_h - 1'b1);

        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        holder_next = holder_reg;

        if (accept)
        begin
            if (in_block && !col_reg[0])
            begin
                holder_next = code;
            end
            if (col_ext + 1'b1 >= w)
            begin
                col_next = '0;
                row_next = (row_ext + 1'b1 >= h) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        // A register write restarts the map.
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fmp_pkg::REG_MAP_WIDTH:
                begin
                    width_next = cfg_data;
                    col_next   = '0;
                    row_next   = '0;
                end
                fmp_pkg::REG_MAP_HEIGHT:
                begin
                    height_next = cfg_data;
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fmp_pkg::SIZE_RESET;
            height_reg <= fmp_pkg::SIZE_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            holder_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            holder_reg <= holder_next;
        end
    end

endmodule

/* hw/rtl/fmp_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_reduce
// Merges the stored upper pair with the lower pair and holds the result.
// ----------------------------------------------------------------------------
module fmp_reduce (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmp_pkg::scan_op_t             op,
    input  logic [fmp_pkg::CODE_W-1:0]    upper,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fmp_pkg::CODE_W-1:0]    pooled_code,
    output logic                          map_done
);

    logic                       s1_valid_reg, s1_valid_next;
    logic [fmp_pkg::CODE_W-1:0] s1_holder_reg, s1_code_reg;
    logic                       s1_last_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [fmp_pkg::CODE_W-1:0] pooled_reg, pooled_next;
    logic                       done_reg, done_next;
    logic                       s1_move;
    logic [fmp_pkg::CODE_W-1:0] best;

    always_comb
    begin
        // The memory read data is valid in the cycle after the read was issued
        // and holds until the next read, which cannot come while s1 is stalled.
        best    = fmp_pkg::keep_larger(upper, s1_holder_reg);
        best    = fmp_pkg::keep_larger(best, s1_code_reg);
        s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
        free    = !s1_valid_reg || s1_move;

        s1_valid_next  = op.rd_en || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && !out_ready);
        pooled_next    = s1_move ? best : pooled_reg;
        done_next      = s1_move ? s1_last_reg : done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.rd_en)
        begin
            s1_holder_reg <= op.holder;
            s1_code_reg   <= op.code;
            s1_last_reg   <= op.last;
        end
        pooled_reg <= pooled_next;
        done_reg   <= done_next;
    end

    assign out_valid   = out_valid_reg;
    assign pooled_code = pooled_reg;
    assign map_done    = done_reg;

endmodule
